// ----- hw/rtl/lcn_pkg.sv -----
// shared types, constants and codes of the least-completed-next scheduler
package lcn_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int IDW           = $clog2(MAX_PROCESSES);
	localparam int LENW          = $clog2(MAX_PROCESSES + 1);
	localparam int UNIT_W        = 16;
	localparam int PID_FIELD_W   = 4;
	localparam int STATUS_W      = 3;

	localparam logic [UNIT_W-1:0] UNIT_MAX = {UNIT_W{1'b1}};

	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_IDLE     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_SERVED   = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_FINISHED = 3'd4;

	typedef logic [IDW-1:0]    pid_t;
	typedef logic [LENW-1:0]   len_t;
	typedef logic [UNIT_W-1:0] unit_t;

	typedef struct packed {
		logic                   action;
		logic [PID_FIELD_W-1:0] process_id;
		unit_t                  service_needed;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [PID_FIELD_W-1:0] served_id;
		unit_t                  turnaround;
		unit_t                  tick_time;
	} out_item_t;

	typedef struct packed {
		unit_t completed;
		unit_t required;
		unit_t arrival;
	} proc_ent_t;

	typedef struct packed {
		logic we;
		pid_t waddr;
		pid_t wdata;
		pid_t raddr;
	} q_req_t;

	typedef struct packed {
		logic      we;
		pid_t      waddr;
		proc_ent_t wdata;
		pid_t      raddr;
	} p_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE,
		S_UPDATE,
		S_EMIT
	} state_t;

endpackage

// ----- hw/rtl/lcn_req_if.sv -----
// request channel: one arrival or tick item per transfer
interface lcn_req_if
	import lcn_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ----- hw/rtl/lcn_rsp_if.sv -----
// response channel: one result item per transfer
interface lcn_rsp_if
	import lcn_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ----- hw/rtl/lcn_ram.sv -----
// simple dual-port ram, one write and one registered read port
module lcn_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hw/rtl/lcn_ctrl.sv -----
// sequencer: arrival, minimum scan, queue compaction, write-back and result register
module lcn_ctrl
	import lcn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	lcn_req_if.sink      request,
	lcn_rsp_if.source    response,
	output q_req_t       q_req,
	input  pid_t         q_rdata,
	output p_req_t       p_req,
	input  proc_ent_t    p_rdata
);
	state_t    state_q, state_d;
	unit_t     time_q, now_q;
	len_t      len_q, cnt_q;
	logic [MAX_PROCESSES-1:0] inq_q;
	out_item_t res_q, out_data_q;
	logic      out_valid_q;

	logic      valid_s1, valid_s2;
	pid_t      k_s1, k_s2, pid_s2;

	pid_t      best_pos_q, best_pid_q;
	proc_ent_t best_ent_q;

	logic      accept, arr_ok, better, scan_done, move_done, out_free, issue;
	logic      fin;
	pid_t      in_pid, final_pos;
	unit_t     need, new_comp, turnaround;
	logic [UNIT_W:0] ta_wide;

	assign in_pid   = IDW'(request.item.process_id);
	assign need     = (request.item.service_needed == '0) ? unit_t'(1)
	                                                      : request.item.service_needed;
	assign accept   = request.valid && request.ready;
	assign arr_ok   = (32'(request.item.process_id) < MAX_PROCESSES) && !inq_q[in_pid]
	                  && (len_q < len_t'(MAX_PROCESSES));
	assign issue    = cnt_q < len_q;
	assign out_free = !out_valid_q || response.ready;

	// candidate compare: fewer units, then earlier arrival, then earlier position
	assign better = (k_s2 == '0) || (p_rdata.completed < best_ent_q.completed)
	                || ((p_rdata.completed == best_ent_q.completed)
	                    && (p_rdata.arrival < best_ent_q.arrival));
	assign final_pos = better ? k_s2 : best_pos_q;
	assign scan_done = valid_s2 && ((len_t'(k_s2) + len_t'(1)) == len_q);
	assign move_done = !valid_s1 && !issue;

	assign new_comp = (best_ent_q.completed == UNIT_MAX) ? best_ent_q.completed
	                                                    : best_ent_q.completed + unit_t'(1);
	assign fin      = new_comp >= best_ent_q.required;
	assign ta_wide  = {1'b0, now_q} - {1'b0, best_ent_q.arrival} + (UNIT_W+1)'(1);
	assign turnaround = ta_wide[UNIT_W] ? UNIT_MAX : ta_wide[UNIT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (request.item.action == ACT_TICK && len_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_MOVE;
				end
			end
			S_MOVE: begin
				if (move_done) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory requests and handshake outputs
	always_comb begin
		q_req         = '0;
		p_req         = '0;
		request.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				request.ready = 1'b1;
				if (request.valid && request.item.action == ACT_ARRIVE && arr_ok) begin
					q_req.we    = 1'b1;
					q_req.waddr = len_q[IDW-1:0];
					q_req.wdata = in_pid;
					p_req.we    = 1'b1;
					p_req.waddr = in_pid;
					p_req.wdata = '{completed: '0, required: need, arrival: time_q};
				end
			end
			S_SCAN: begin
				q_req.raddr = cnt_q[IDW-1:0];
				p_req.raddr = q_rdata;
			end
			S_MOVE: begin
				q_req.raddr = cnt_q[IDW-1:0];
				if (valid_s1) begin
					q_req.we    = 1'b1;
					q_req.waddr = k_s1 - pid_t'(1);
					q_req.wdata = q_rdata;
				end
			end
			S_UPDATE: begin
				p_req.we    = 1'b1;
				p_req.waddr = best_pid_q;
				p_req.wdata = '{completed: new_comp, required: best_ent_q.required,
				                arrival: best_ent_q.arrival};
				if (!fin) begin
					q_req.we    = 1'b1;
					q_req.waddr = pid_t'(len_q - len_t'(1));
					q_req.wdata = best_pid_q;
				end
			end
			default: begin
				q_req = '0;
			end
		endcase
	end

	assign response.valid = out_valid_q;
	assign response.item  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			time_q      <= '0;
			now_q       <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			inq_q       <= '0;
			res_q       <= '0;
			out_data_q  <= '0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			k_s1        <= '0;
			k_s2        <= '0;
			pid_s2      <= '0;
			best_pos_q  <= '0;
			best_pid_q  <= '0;
			best_ent_q  <= '0;
		end else begin
			state_q <= state_d;
			if (response.valid && response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						now_q <= time_q;
						if (request.item.action == ACT_TICK) begin
							if (time_q != UNIT_MAX) begin
								time_q <= time_q + unit_t'(1);
							end
							res_q    <= '{STATUS_IDLE, '0, '0, time_q};
							cnt_q    <= '0;
							valid_s1 <= 1'b0;
							valid_s2 <= 1'b0;
						end else if (arr_ok) begin
							res_q         <= '{STATUS_ACCEPTED, request.item.process_id,
							                   '0, time_q};
							inq_q[in_pid] <= 1'b1;
							len_q         <= len_q + len_t'(1);
						end else begin
							res_q <= '{STATUS_REJECTED, request.item.process_id, '0, time_q};
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + len_t'(1);
					end
					valid_s1 <= issue;
					k_s1     <= cnt_q[IDW-1:0];
					valid_s2 <= valid_s1;
					k_s2     <= k_s1;
					pid_s2   <= q_rdata;
					if (valid_s2 && better) begin
						best_pos_q <= k_s2;
						best_pid_q <= pid_s2;
						best_ent_q <= p_rdata;
					end
					if (scan_done) begin
						cnt_q    <= len_t'(final_pos) + len_t'(1);
						valid_s1 <= 1'b0;
					end
				end
				S_MOVE: begin
					if (issue) begin
						cnt_q <= cnt_q + len_t'(1);
					end
					valid_s1 <= issue;
					k_s1     <= cnt_q[IDW-1:0];
				end
				S_UPDATE: begin
					if (fin) begin
						inq_q[best_pid_q] <= 1'b0;
						len_q             <= len_q - len_t'(1);
						res_q <= '{STATUS_FINISHED, PID_FIELD_W'(best_pid_q), turnaround, now_q};
					end else begin
						res_q <= '{STATUS_SERVED, PID_FIELD_W'(best_pid_q), '0, now_q};
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
					end
				end
				default: begin
					valid_s1 <= 1'b0;
				end
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= len_t'(MAX_PROCESSES))
		else $error("queue length beyond capacity");

	a_len_matches_members: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(inq_q) == int'(len_q))
		else $error("queue length and membership bits disagree");

	a_served_is_queued: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPDATE |-> inq_q[best_pid_q])
		else $error("selected process not in queue");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> time_q >= $past(time_q))
		else $error("time counter went backwards");

	a_idle_only_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && accept && request.item.action == ACT_TICK && len_q != '0)
		|=> state_q == S_SCAN)
		else $error("tick on non-empty queue did not start a scan");
endmodule

// ----- hw/rtl/least_completed_next_scheduler.sv -----
// top level of the least-completed-next scheduler
// An arrival, a rejection or a tick on an empty queue goes from the idle state straight to
// the emit state, which loads its result into the result register. A tick on a queue of L
// entries reads the queue ram once per entry to find the process with the fewest completed
// units, with the process table read behind it at each id that the queue ram returns, then
// reads the queue ram once per entry behind the chosen one to close up the queue, followed
// by the write-back state and the emit state. One item is worked on at a time; the result
// register lets a new item be taken while the previous result still waits. No clearing
// pass follows reset.
module least_completed_next_scheduler
	import lcn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	lcn_req_if.sink   request,
	lcn_rsp_if.source response
);
	q_req_t    q_req;
	p_req_t    p_req;
	pid_t      q_rdata;
	proc_ent_t p_rdata;

	lcn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response),
		.q_req    (q_req),
		.q_rdata  (q_rdata),
		.p_req    (p_req),
		.p_rdata  (p_rdata)
	);

	// ready queue: process ids by queue position
	lcn_ram #(
		.DATA_W (IDW),
		.ADDR_W (IDW)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_req.we),
		.waddr (q_req.waddr),
		.wdata (q_req.wdata),
		.raddr (q_req.raddr),
		.rdata (q_rdata)
	);

	// process table: completed, required and arrival per process
	lcn_ram #(
		.DATA_W ($bits(proc_ent_t)),
		.ADDR_W (IDW)
	) u_proc_ram (
		.clk   (clk),
		.we    (p_req.we),
		.waddr (p_req.waddr),
		.wdata (p_req.wdata),
		.raddr (p_req.raddr),
		.rdata (p_rdata)
	);
endmodule
